@@ design/lru_page_replacement_top_assert.svh @@
// assertion macros for the lru page replacement block
// depends on nothing; included by the checker module
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// property checked while out of reset
`define LRU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define LRU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lru_pr_pkg.sv @@
// shared widths, constants and types of the lru page replacement block
// no dependencies
package lru_pr_pkg;

  localparam int unsigned REF_PAGE_W = 16;
  localparam int unsigned RESIDENT_W = 4;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  // register index taken from paddr[2]
  localparam logic REG_IDX_FRAME_LIMIT = 1'b0;

  typedef struct packed {
    logic                  miss;
    logic                  evicted_valid;
    logic [REF_PAGE_W-1:0] evicted_page;
    logic [RESIDENT_W-1:0] resident;
    logic [COUNT_W-1:0]    miss_total;
    logic                  string_done;
  } lru_pr_result_t;

endpackage

@@ design/lru_pr_in_if.sv @@
// input channel of the lru page replacement block: one page reference per word
// depends on lru_pr_pkg
interface lru_pr_in_if import lru_pr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REF_PAGE_W-1:0] ref_page;
  logic                  last_ref;

  modport source (output valid, ref_page, last_ref, input ready);
  modport sink   (input valid, ref_page, last_ref, output ready);
endinterface

@@ design/lru_pr_out_if.sv @@
// result channel of the lru page replacement block: one result per word
// depends on lru_pr_pkg
interface lru_pr_out_if import lru_pr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  miss;
  logic                  evicted_valid;
  logic [REF_PAGE_W-1:0] evicted_page;
  logic [RESIDENT_W-1:0] resident;
  logic [COUNT_W-1:0]    miss_total;
  logic                  string_done;

  modport source (output valid, miss, evicted_valid, evicted_page, resident, miss_total,
                  string_done, input ready);
  modport sink   (input valid, miss, evicted_valid, evicted_page, resident, miss_total,
                  string_done, output ready);
endinterface

@@ design/lru_pr_apb.sv @@
// apb register file of the lru page replacement block: frame_limit
// depends on lru_pr_pkg
module lru_pr_apb import lru_pr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LIMIT_W-1:0]    frame_limit_o
);

  logic                 reg_idx;
  logic                 wr_en;
  logic [LIMIT_W-1:0]   frame_limit_q;

  assign reg_idx = paddr[APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_IDX_FRAME_LIMIT);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      frame_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IDX_FRAME_LIMIT: prdata = APB_DATA_W'(frame_limit_q);
      default:             prdata = '0;
    endcase
  end

  assign frame_limit_o = frame_limit_q;

endmodule

@@ design/lru_pr_stack.sv @@
// recency stack, occupancy and miss counter, updated on each step
// depends on lru_pr_pkg
module lru_pr_stack import lru_pr_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [REF_PAGE_W-1:0] ref_page_i,
  input  logic                  last_ref_i,
  input  logic [LIMIT_W-1:0]    frame_limit_i,
  output lru_pr_result_t        result_o
);

  localparam int unsigned OCC_W = $clog2(FRAMES + 1);
  localparam int unsigned CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

  logic [PAGE_BITS-1:0] stack_q [FRAMES];
  logic [PAGE_BITS-1:0] upper   [FRAMES];
  logic [OCC_W-1:0]     occ_q, occ_d, occ_m1, lim;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [PAGE_BITS-1:0] page;
  logic [FRAMES-1:0]    match, above, shift_en, page_wr;
  logic                 hit, full, evict;

  assign page   = PAGE_BITS'(ref_page_i);
  assign occ_m1 = occ_q - 1'b1;

  // frame_limit of zero acts as one, above the built count as the built count
  always_comb begin
    if (frame_limit_i == '0) begin
      lim = OCC_W'(1);
    end else if (CMP_W'(frame_limit_i) > CMP_W'(FRAMES)) begin
      lim = OCC_W'(FRAMES);
    end else begin
      lim = OCC_W'(frame_limit_i);
    end
  end

  assign hit   = |match;
  assign full  = (occ_q >= lim);
  assign evict = !hit && full;

  for (genvar k = 0; k < FRAMES; k++) begin : g_entry
    assign match[k] = (OCC_W'(k) < occ_q) && (stack_q[k] == page);
    assign above[k] = |match[k:0];
    assign shift_en[k] = (hit ? above[k] : full) && (OCC_W'(k + 1) < occ_q);
    assign page_wr[k]  = (hit || full) ? (OCC_W'(k) == occ_m1) : (OCC_W'(k) == occ_q);

    if (k == FRAMES - 1) begin : g_top
      assign upper[k] = stack_q[k];
    end else begin : g_mid
      assign upper[k] = stack_q[k + 1];
    end

    always_ff @(posedge clk_i) begin
      if (step_i) begin
        if (shift_en[k]) begin
          stack_q[k] <= upper[k];
        end else if (page_wr[k]) begin
          stack_q[k] <= page;
        end
      end
    end
  end

  assign occ_d = (hit || full) ? occ_q : occ_q + 1'b1;

  always_comb begin
    count_d = count_q;
    if (!hit && (count_q != COUNT_MAX)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      if (last_ref_i) begin
        occ_q   <= '0;
        count_q <= '0;
      end else begin
        occ_q   <= occ_d;
        count_q <= count_d;
      end
    end
  end

  always_comb begin
    result_o.miss          = !hit;
    result_o.evicted_valid = evict;
    result_o.evicted_page  = evict ? REF_PAGE_W'(stack_q[0]) : '0;
    result_o.resident      = RESIDENT_W'(occ_d);
    result_o.miss_total    = count_d;
    result_o.string_done   = last_ref_i;
  end

endmodule

@@ design/lru_page_replacement_top.sv @@
// lru page replacement: recency stack of up to FRAMES pages, one reference per word
// input register then result register; one word per cycle unless output stalls
// each reference updates the stack as it moves from input to result register
// async active-low reset empties the stack, zeroes the miss count, frame_limit to 4
// depends on lru_pr_pkg, lru_pr_in_if, lru_pr_out_if, lru_pr_apb, lru_pr_stack
module lru_page_replacement_top import lru_pr_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lru_pr_in_if.sink             in_i,
  lru_pr_out_if.source          out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                  in_valid_q;
  logic [REF_PAGE_W-1:0] ref_page_q;
  logic                  last_ref_q;
  logic                  out_valid_q;
  lru_pr_result_t        out_q;
  lru_pr_result_t        result;
  logic [LIMIT_W-1:0]    frame_limit;
  logic                  advance;
  logic                  in_ready;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;

  lru_pr_apb u_apb (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .frame_limit_o (frame_limit)
  );

  lru_pr_stack #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_stack (
    .clk_i,
    .rst_ni,
    .step_i        (advance),
    .ref_page_i    (ref_page_q),
    .last_ref_i    (last_ref_q),
    .frame_limit_i (frame_limit),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      ref_page_q <= in_i.ref_page;
      last_ref_q <= in_i.last_ref;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.miss          = out_q.miss;
  assign out_o.evicted_valid = out_q.evicted_valid;
  assign out_o.evicted_page  = out_q.evicted_page;
  assign out_o.resident      = out_q.resident;
  assign out_o.miss_total    = out_q.miss_total;
  assign out_o.string_done   = out_q.string_done;

endmodule

@@ design/lru_pr_checker.sv @@
// port-level checks of the lru page replacement result channel, bound to the top
// depends on lru_pr_pkg and lru_page_replacement_top_assert.svh
module lru_pr_checker import lru_pr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  miss,
  input logic                  evicted_valid,
  input logic [REF_PAGE_W-1:0] evicted_page,
  input logic [RESIDENT_W-1:0] resident,
  input logic [COUNT_W-1:0]    miss_total
);

`include "lru_page_replacement_top_assert.svh"

  `LRU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(miss_total), "result word dropped or changed while stalled")
  `LRU_ASSERT(a_evict_is_miss, clk_i, rst_ni, out_valid && evicted_valid |-> miss, "eviction reported on a hit")
  `LRU_ASSERT(a_evict_page_zero, clk_i, rst_ni, out_valid && !evicted_valid |-> evicted_page == '0, "evicted page nonzero without eviction")
  `LRU_ASSERT(a_resident_nonzero, clk_i, rst_ni, out_valid |-> resident != '0, "empty stack after a reference")
  `LRU_ASSERT(a_miss_counted, clk_i, rst_ni, out_valid && miss |-> miss_total != '0, "miss not counted")

endmodule

bind lru_page_replacement_top lru_pr_checker u_lru_pr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .miss          (out_o.miss),
  .evicted_valid (out_o.evicted_valid),
  .evicted_page  (out_o.evicted_page),
  .resident      (out_o.resident),
  .miss_total    (out_o.miss_total)
);
